@@ rtl/core/rob_pkg.sv @@
// ----------------------------------------------------------------------------
// rob_pkg: shared types and constants for the reorder buffer
// Buffer depth, pointer and count widths, operation and status codes, and the
// write-control bundle passed from the pointer logic to the entry store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rob_pkg;

	localparam int DEPTH = 8;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Fixed field widths of the stream words.
	localparam int OP_W   = 2;
	localparam int DEST_W = 16;
	localparam int INSTR_W = 16;
	localparam int TAG_W  = 3;
	localparam int VAL_W  = 32;
	localparam int OCC_W  = 4;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC  = 2'd0,
		OP_CMPL   = 2'd1,
		OP_RETIRE = 2'd2,
		OP_NOP    = 2'd3
	} rob_op_t;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	// Writes into the entry store for the operation that advances this cycle.
	typedef struct packed {
		logic             alloc_en;
		logic             cmpl_en;
		logic [PTR_W-1:0] tail;
		logic [PTR_W-1:0] tag;
		logic [PTR_W-1:0] nxt_head;
	} rob_wr_t;

endpackage

@@ rtl/core/rob_ctrl.sv @@
// ----------------------------------------------------------------------------
// rob_ctrl: head, tail and fill count of the reorder buffer
// Decodes one operation, decides whether it takes effect and advances the
// pointers and count when the operation leaves the input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rob_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  rob_pkg::rob_op_t          op,
	input  logic [rob_pkg::TAG_W-1:0] tag_in,
	output rob_pkg::rob_wr_t          wr,
	output logic [rob_pkg::TAG_W-1:0] alloc_tag,
	output logic                      status,
	output logic [rob_pkg::CNT_W-1:0] nxt_cnt
);
	import rob_pkg::*;

	localparam logic [PTR_W:0] DEPTH_X = (PTR_W + 1)'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] cnt_q;

	logic             is_full;
	logic             is_empty;
	logic             tag_ok;
	logic [PTR_W-1:0] tag_p;
	logic [PTR_W:0]   offset;
	logic             in_range;
	logic             do_alloc;
	logic             do_cmpl;
	logic             do_retire;
	logic [PTR_W-1:0] nxt_head;
	logic [PTR_W-1:0] nxt_tail;

	assign is_full  = (cnt_q == FULL_CNT);
	assign is_empty = (cnt_q == '0);
	assign tag_ok   = (int'(tag_in) < DEPTH);
	assign tag_p    = PTR_W'(tag_in);

	// Distance of the tag from the head, modulo the depth.
	always_comb begin
		if (tag_p >= head_q) begin
			offset = {1'b0, tag_p} - {1'b0, head_q};
		end else begin
			offset = {1'b0, tag_p} + DEPTH_X - {1'b0, head_q};
		end
	end

	assign in_range  = tag_ok && (offset < (PTR_W + 1)'(cnt_q));
	assign do_alloc  = (op == OP_ALLOC) && !is_full;
	assign do_cmpl   = (op == OP_CMPL) && in_range;
	assign do_retire = (op == OP_RETIRE) && !is_empty;

	assign nxt_head = do_retire ? ((head_q == LAST_PTR) ? '0 : head_q + 1'b1) : head_q;
	assign nxt_tail = do_alloc ? ((tail_q == LAST_PTR) ? '0 : tail_q + 1'b1) : tail_q;

	always_comb begin
		nxt_cnt = cnt_q;
		if (do_alloc) begin
			nxt_cnt = cnt_q + 1'b1;
		end else if (do_retire) begin
			nxt_cnt = cnt_q - 1'b1;
		end
	end

	assign alloc_tag = do_alloc ? TAG_W'(tail_q) : '0;
	assign status    = ((op == OP_ALLOC) && is_full) ? ST_FULL : ST_OK;

	assign wr.alloc_en = adv && do_alloc;
	assign wr.cmpl_en  = adv && do_cmpl;
	assign wr.tail     = tail_q;
	assign wr.tag      = tag_p;
	assign wr.nxt_head = nxt_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (adv) begin
			head_q <= nxt_head;
			tail_q <= nxt_tail;
			cnt_q  <= nxt_cnt;
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("fill count above depth");

	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(is_empty || is_full) |-> (head_q == tail_q))
		else $error("head and tail differ on empty or full buffer");

	a_refused_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (op == OP_ALLOC) && is_full) |=> (is_full && $stable(tail_q)))
		else $error("refused allocate changed the buffer");

	a_retire_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (op == OP_RETIRE) && is_empty) |=> (is_empty && $stable(head_q)))
		else $error("retire on empty buffer changed the buffer");
`endif

endmodule

@@ rtl/core/rob_store.sv @@
// ----------------------------------------------------------------------------
// rob_store: entry fields of the reorder buffer
// Holds ready, destination, value and instruction index per entry and reads
// the entry at the head that follows the current operation, with bypass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rob_store (
	input  logic                        clk,
	input  rob_pkg::rob_wr_t            wr,
	input  logic [rob_pkg::DEST_W-1:0]  dest_reg,
	input  logic [rob_pkg::INSTR_W-1:0] instr_id,
	input  logic [rob_pkg::VAL_W-1:0]   result_value,
	output logic                        head_ready,
	output logic [rob_pkg::DEST_W-1:0]  head_dest,
	output logic [rob_pkg::VAL_W-1:0]   head_value,
	output logic [rob_pkg::INSTR_W-1:0] head_instr
);
	import rob_pkg::*;

	logic               ready_q [DEPTH];
	logic [DEST_W-1:0]  dest_q  [DEPTH];
	logic [VAL_W-1:0]   value_q [DEPTH];
	logic [INSTR_W-1:0] instr_q [DEPTH];

	// An entry is always written by allocate before the head can reach it.
	always_ff @(posedge clk) begin
		if (wr.alloc_en) begin
			ready_q[wr.tail] <= 1'b0;
			dest_q[wr.tail]  <= dest_reg;
			value_q[wr.tail] <= '0;
			instr_q[wr.tail] <= instr_id;
		end
		if (wr.cmpl_en) begin
			ready_q[wr.tag] <= 1'b1;
			value_q[wr.tag] <= result_value;
		end
	end

	// Head view after this operation: bypass the write aimed at the new head.
	always_comb begin
		head_ready = ready_q[wr.nxt_head];
		head_dest  = dest_q[wr.nxt_head];
		head_value = value_q[wr.nxt_head];
		head_instr = instr_q[wr.nxt_head];
		if (wr.alloc_en && (wr.tail == wr.nxt_head)) begin
			head_ready = 1'b0;
			head_dest  = dest_reg;
			head_value = '0;
			head_instr = instr_id;
		end else if (wr.cmpl_en && (wr.tag == wr.nxt_head)) begin
			head_ready = 1'b1;
			head_value = result_value;
		end
	end

endmodule

@@ rtl/core/reorder_buffer_top.sv @@
// ----------------------------------------------------------------------------
// reorder_buffer_top: circular reorder buffer with stream ports
// The buffer keeps eight entries in issue order. Each input word carries one
// operation: allocate writes a busy, not-ready entry at the tail and returns
// its tag (or reports status 1 and changes nothing when the buffer is full);
// complete writes a value into an occupied entry and marks it ready (a tag
// outside the occupied range is ignored); retire frees the head entry (no
// effect when empty); opcode three does nothing. Every input word produces
// exactly one output word that shows the head entry, the occupancy and the
// full and empty flags as they stand after the operation; with an empty
// buffer all head fields read zero. A word is registered on entry, worked
// combinationally through the pointer logic and the entry store, and
// registered on exit, so the buffer takes one word per clock while the
// receiver keeps taking results. While the receiver holds off, the output
// register keeps its result and the input register keeps the next word;
// once both are occupied the input ready goes low until the receiver takes
// the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reorder_buffer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// opcode[1:0], dest_reg[17:2], instr_id[33:18], tag_in[36:34],
	// result_value[68:37], zero fill [71:69]
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// alloc_tag[2:0], status[3], is_full[4], is_empty[5], occupancy[9:6],
	// head_valid[10], head_ready[11], head_dest[27:12], head_value[59:28],
	// head_instr[75:60], zero fill [79:76]
	output logic [79:0] m_axis_tdata
);
	import rob_pkg::*;

	// Input register.
	logic               valid_s1;
	rob_op_t            op_s1;
	logic [DEST_W-1:0]  dest_s1;
	logic [INSTR_W-1:0] instr_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic [VAL_W-1:0]   val_s1;

	// Output register.
	logic               out_valid_q;
	logic [79:0]        out_data_q;

	logic               adv;
	logic               in_acc;
	rob_wr_t            wr;
	logic [TAG_W-1:0]   alloc_tag;
	logic               status;
	logic [CNT_W-1:0]   nxt_cnt;
	logic               hd_ready;
	logic [DEST_W-1:0]  hd_dest;
	logic [VAL_W-1:0]   hd_value;
	logic [INSTR_W-1:0] hd_instr;
	logic               hv;
	logic [79:0]        res_word;

	// The registered word moves on when the output register is free or is
	// being emptied in this cycle.
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1    <= rob_op_t'(s_axis_tdata[1:0]);
			dest_s1  <= s_axis_tdata[17:2];
			instr_s1 <= s_axis_tdata[33:18];
			tag_s1   <= s_axis_tdata[36:34];
			val_s1   <= s_axis_tdata[68:37];
		end
	end

	rob_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.op        (op_s1),
		.tag_in    (tag_s1),
		.wr        (wr),
		.alloc_tag (alloc_tag),
		.status    (status),
		.nxt_cnt   (nxt_cnt)
	);

	rob_store u_store (
		.clk          (clk),
		.wr           (wr),
		.dest_reg     (dest_s1),
		.instr_id     (instr_s1),
		.result_value (val_s1),
		.head_ready   (hd_ready),
		.head_dest    (hd_dest),
		.head_value   (hd_value),
		.head_instr   (hd_instr)
	);

	// Head fields are forced to zero when the buffer ends up empty.
	assign hv = (nxt_cnt != '0);

	assign res_word = {
		4'b0,
		hv ? hd_instr : {INSTR_W{1'b0}},
		hv ? hd_value : {VAL_W{1'b0}},
		hv ? hd_dest  : {DEST_W{1'b0}},
		hv && hd_ready,
		hv,
		OCC_W'(nxt_cnt),
		!hv,
		(nxt_cnt == CNT_W'(DEPTH)),
		status,
		alloc_tag
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res_word;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
